[sv/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on i_clk, gated by i_rst_n
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[sv/lldr_pkg.sv]
// ---------------------------------------------------------------------------
// lldr_pkg
// types, constants and constant tables of the light level regulator
// ---------------------------------------------------------------------------
package lldr_pkg;

    localparam int BAR_LEDS  = 8;
    localparam int DUTY_FULL = 100;

    localparam int ADC_W    = 8;
    localparam int DUTY_W   = 7;
    localparam int LED_W    = 8;
    localparam int LUX_W    = 12;
    localparam int SP_W     = 10;
    localparam int DB_W     = 8;
    localparam int STEP_W   = 7;
    localparam int CFG_W    = 10;
    localparam int CFG_IDX_W = 2;

    localparam logic [SP_W-1:0]   TARGET_RST   = 10'd400;
    localparam logic [DUTY_W-1:0] DUTY_RST     = 7'd50;
    localparam logic [DB_W-1:0]   DEADBAND_RST = 8'd10;
    localparam logic [STEP_W-1:0] SP_STEP_RST  = 7'd10;
    localparam logic [SP_W-1:0]   SP_MIN_RST   = 10'd10;
    localparam logic [SP_W-1:0]   SP_MAX_RST   = 10'd1000;

    localparam longint LUX_GAIN_Q20 = 64'sd231105118;
    localparam longint LUX_CENTER   = 64'sd1000;
    localparam int     REF_RES      = 400;
    localparam int     RES_SCALE    = 10000;
    localparam int     ADC_FULL     = 255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEADBAND = 2'd0,
        CFG_SP_STEP  = 2'd1,
        CFG_SP_MIN   = 2'd2,
        CFG_SP_MAX   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [DB_W-1:0]   deadband;
        logic [STEP_W-1:0] setpoint_step;
        logic [SP_W-1:0]   setpoint_min;
        logic [SP_W-1:0]   setpoint_max;
    } t_cfg;

    typedef struct packed {
        logic plus_level;
        logic minus_level;
        logic menu_edge;
    } t_btn;

    // setpoint unit -> duty unit
    typedef struct packed {
        logic            menu_next;
        logic [SP_W-1:0] target;
    } t_sp_status;

    typedef logic signed [LUX_W-1:0] t_lux_rom [2**ADC_W];
    typedef logic [LED_W-1:0]        t_led_rom [2**DUTY_W];

    // log2 in Q28 by normalization and repeated squaring
    function automatic logic [63:0] log2_q28(input logic [31:0] r_in);
        logic [31:0] r;
        int unsigned n;
        logic [63:0] m;
        logic [63:0] res;
        r = (r_in == 32'd0) ? 32'd1 : r_in;
        n = 0;
        for (int k = 0; k < 30; k++) begin
            if ((r >> (n + 1)) != 32'd0) n++;
        end
        m   = {32'd0, r} << (30 - n);
        res = 64'(n) << 28;
        for (int i = 27; i >= 0; i--) begin
            m = (m * m) >> 30;
            if (m >= 64'h0000_0000_8000_0000) begin
                m      = m >> 1;
                res[i] = 1'b1;
            end
        end
        return res;
    endfunction

    // restoring long division, used only while building the table
    function automatic logic [31:0] udiv22(input logic [31:0] num, input logic [31:0] den);
        logic [31:0] q;
        logic [31:0] rem;
        q   = 32'd0;
        rem = 32'd0;
        for (int b = 21; b >= 0; b--) begin
            rem = {rem[30:0], num[b]};
            if (rem >= den) begin
                rem  = rem - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic signed [LUX_W-1:0] sample_to_lux(input int x);
        logic [31:0] r;
        longint d;
        longint t;
        longint lux;
        if (x == 0) return 12'sd2047;
        if (x >= ADC_FULL) return -12'sd2048;
        r   = udiv22(32'(RES_SCALE * x), 32'(ADC_FULL - x));
        d   = longint'(log2_q28(r)) - longint'(log2_q28(32'(REF_RES)));
        t   = (LUX_CENTER <<< 48) - d * LUX_GAIN_Q20;
        if (t >= 0) lux = t >>> 48;
        else lux = -((-t) >>> 48);
        if (lux > 2047) lux = 2047;
        if (lux < -2048) lux = -2048;
        return LUX_W'(lux);
    endfunction

    function automatic t_lux_rom build_lux_rom();
        t_lux_rom rom;
        for (int x = 0; x < 2**ADC_W; x++) rom[x] = sample_to_lux(x);
        return rom;
    endfunction

    function automatic t_led_rom build_led_rom();
        t_led_rom rom;
        int lit;
        logic [31:0] bar;
        for (int d = 0; d < 2**DUTY_W; d++) begin
            lit = (d * BAR_LEDS) / DUTY_FULL;
            if (lit > 16) lit = 16;
            bar    = (32'd1 << lit) - 32'd1;
            rom[d] = bar[LED_W-1:0];
        end
        return rom;
    endfunction

    localparam t_lux_rom LUX_ROM = build_lux_rom();
    localparam t_led_rom LED_ROM = build_led_rom();

endpackage

[sv/lldr_in_if.sv]
// ---------------------------------------------------------------------------
// lldr_in_if
// sample channel: sensor code and button levels
// ---------------------------------------------------------------------------
interface lldr_in_if;
    logic                         valid;
    logic                         ready;
    logic [lldr_pkg::ADC_W-1:0]   adc_sample;
    logic                         plus_level;
    logic                         minus_level;
    logic                         menu_edge;

    modport source (output valid, output adc_sample, output plus_level,
                    output minus_level, output menu_edge, input ready);
    modport sink   (input valid, input adc_sample, input plus_level,
                    input minus_level, input menu_edge, output ready);
endinterface

[sv/lldr_out_if.sv]
// ---------------------------------------------------------------------------
// lldr_out_if
// result channel: duty, led bar, lux, setpoint and menu flag
// ---------------------------------------------------------------------------
interface lldr_out_if;
    logic                                valid;
    logic                                ready;
    logic [lldr_pkg::DUTY_W-1:0]         duty_percent;
    logic [lldr_pkg::LED_W-1:0]          led_bar;
    logic signed [lldr_pkg::LUX_W-1:0]   lux_value;
    logic [lldr_pkg::SP_W-1:0]           setpoint_value;
    logic                                menu_mode;

    modport source (output valid, output duty_percent, output led_bar, output lux_value,
                    output setpoint_value, output menu_mode, input ready);
    modport sink   (input valid, input duty_percent, input led_bar, input lux_value,
                    input setpoint_value, input menu_mode, output ready);
endinterface

[sv/lldr_setpoint.sv]
// ---------------------------------------------------------------------------
// lldr_setpoint
// menu mode toggle, button press latching and setpoint stepping
// ---------------------------------------------------------------------------
module lldr_setpoint (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_fire,
    input  lldr_pkg::t_btn          i_btn,
    input  lldr_pkg::t_cfg          i_cfg,
    output lldr_pkg::t_sp_status    o_status,
    output logic [lldr_pkg::SP_W-1:0] o_target_cur
);
    logic                      r_menu;
    logic                      r_plus_lat;
    logic                      r_minus_lat;
    logic [lldr_pkg::SP_W-1:0] r_target;

    logic                      n_menu;
    logic                      n_plus_lat;
    logic                      n_minus_lat;
    logic [lldr_pkg::SP_W-1:0] n_target;

    always_comb begin
        logic [lldr_pkg::SP_W:0] w_sum;
        logic [lldr_pkg::SP_W:0] w_lim;
        n_menu      = r_menu ^ i_btn.menu_edge;
        n_plus_lat  = r_plus_lat;
        n_minus_lat = r_minus_lat;
        n_target    = r_target;
        w_sum       = '0;
        w_lim       = '0;
        if (n_menu) begin
            // plus first, minus sees its result
            if (!r_plus_lat && !i_btn.plus_level) begin
                n_plus_lat = 1'b1;
                if (n_target < i_cfg.setpoint_max) begin
                    w_sum    = {1'b0, n_target} + (lldr_pkg::SP_W+1)'(i_cfg.setpoint_step);
                    n_target = (w_sum > {1'b0, i_cfg.setpoint_max}) ? i_cfg.setpoint_max
                                                                    : w_sum[lldr_pkg::SP_W-1:0];
                end else begin
                    n_target = i_cfg.setpoint_max;
                end
            end else if (i_btn.plus_level) begin
                n_plus_lat = 1'b0;
            end
            if (!r_minus_lat && !i_btn.minus_level) begin
                n_minus_lat = 1'b1;
                if (n_target > i_cfg.setpoint_min) begin
                    w_lim    = {1'b0, i_cfg.setpoint_min}
                             + (lldr_pkg::SP_W+1)'(i_cfg.setpoint_step);
                    n_target = ({1'b0, n_target} >= w_lim)
                             ? n_target - lldr_pkg::SP_W'(i_cfg.setpoint_step)
                             : i_cfg.setpoint_min;
                end else begin
                    n_target = i_cfg.setpoint_min;
                end
            end else if (i_btn.minus_level) begin
                n_minus_lat = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_menu      <= 1'b0;
            r_plus_lat  <= 1'b0;
            r_minus_lat <= 1'b0;
            r_target    <= lldr_pkg::TARGET_RST;
        end else if (i_fire) begin
            r_menu      <= n_menu;
            r_plus_lat  <= n_plus_lat;
            r_minus_lat <= n_minus_lat;
            r_target    <= n_target;
        end
    end

    assign o_status.menu_next = n_menu;
    assign o_status.target    = n_target;
    assign o_target_cur       = r_target;
endmodule

[sv/lldr_duty.sv]
// ---------------------------------------------------------------------------
// lldr_duty
// deadband duty regulation and led bar lookup
// ---------------------------------------------------------------------------
module lldr_duty (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_fire,
    input  lldr_pkg::t_sp_status              i_status,
    input  logic signed [lldr_pkg::LUX_W-1:0] i_lux,
    input  logic [lldr_pkg::DB_W-1:0]         i_deadband,
    output logic [lldr_pkg::DUTY_W-1:0]       o_duty_next,
    output logic [lldr_pkg::LED_W-1:0]        o_led_next
);
    localparam int CMP_W = lldr_pkg::SP_W + 3;

    logic [lldr_pkg::DUTY_W-1:0] r_duty;
    logic [lldr_pkg::DUTY_W-1:0] n_duty;

    logic signed [CMP_W-1:0] w_lux;
    logic signed [CMP_W-1:0] w_lo;
    logic signed [CMP_W-1:0] w_hi;

    assign w_lux = CMP_W'(i_lux);
    assign w_lo  = $signed(CMP_W'(i_status.target)) - $signed(CMP_W'(i_deadband));
    assign w_hi  = $signed(CMP_W'(i_status.target)) + $signed(CMP_W'(i_deadband));

    always_comb begin
        n_duty = r_duty;
        if (!i_status.menu_next) begin
            if (w_lux < w_lo) begin
                if (r_duty < lldr_pkg::DUTY_W'(lldr_pkg::DUTY_FULL)) begin
                    n_duty = r_duty + lldr_pkg::DUTY_W'(1);
                end
            end else if (w_lux > w_hi) begin
                if (r_duty != '0) n_duty = r_duty - lldr_pkg::DUTY_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty <= lldr_pkg::DUTY_RST;
        end else if (i_fire) begin
            r_duty <= n_duty;
        end
    end

    assign o_duty_next = n_duty;
    assign o_led_next  = lldr_pkg::LED_ROM[n_duty];
endmodule

[sv/light_level_deadband_regulator_unit.sv]
// ---------------------------------------------------------------------------
// light_level_deadband_regulator_unit
// light sensor lux conversion with deadband duty regulation and setpoint menu
// ---------------------------------------------------------------------------
// Each sample beat gives exactly one result beat. The 8-bit sensor code is
// turned into signed lux by a 256-entry constant table built at elaboration
// from the sensor's log law (code 0 reads +2047, code 255 reads -2048). Outside
// menu mode the duty moves one percent toward the setpoint whenever lux lies
// outside setpoint +/- deadband, held within 0..100; in menu mode presses of
// the active-low plus and minus buttons step the setpoint within its bounds.
// Throughput is one beat per clock while the result side is not stalled; a beat
// passes through the input register and then the result register, with all of
// the table lookup and state update in one short combinational path between
// them. A new beat is taken while a result waits, as long as the input register
// is free. Configuration writes take effect at once and belong between beats.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module light_level_deadband_regulator_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    lldr_in_if.sink                              i_in,
    lldr_out_if.source                           o_out,
    input  logic                                 i_cfg_we,
    input  logic [lldr_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [lldr_pkg::CFG_W-1:0]           i_cfg_data
);
    // configuration registers
    lldr_pkg::t_cfg r_cfg;

    // input register
    logic                         r_in_vld;
    logic [lldr_pkg::ADC_W-1:0]   r_adc;
    lldr_pkg::t_btn               r_btn;

    // result register
    logic                                r_out_vld;
    logic [lldr_pkg::DUTY_W-1:0]         r_duty;
    logic [lldr_pkg::LED_W-1:0]          r_led;
    logic signed [lldr_pkg::LUX_W-1:0]   r_lux;
    logic [lldr_pkg::SP_W-1:0]           r_sp;
    logic                                r_menu;

    logic                                w_fire;
    logic                                w_in_take;
    logic signed [lldr_pkg::LUX_W-1:0]   w_lux;
    lldr_pkg::t_sp_status                w_status;
    logic [lldr_pkg::SP_W-1:0]           w_target_cur;
    logic [lldr_pkg::DUTY_W-1:0]         w_duty_next;
    logic [lldr_pkg::LED_W-1:0]          w_led_next;

    // held beat moves on when the result register is empty or being drained
    assign w_fire    = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || w_fire;
    assign w_in_take = i_in.valid && i_in.ready;

    // register file, plain writes, no read-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.deadband      <= lldr_pkg::DEADBAND_RST;
            r_cfg.setpoint_step <= lldr_pkg::SP_STEP_RST;
            r_cfg.setpoint_min  <= lldr_pkg::SP_MIN_RST;
            r_cfg.setpoint_max  <= lldr_pkg::SP_MAX_RST;
        end else if (i_cfg_we) begin
            unique case (lldr_pkg::t_cfg_idx'(i_cfg_idx))
                lldr_pkg::CFG_DEADBAND: begin
                    r_cfg.deadband <= i_cfg_data[lldr_pkg::DB_W-1:0];
                end
                lldr_pkg::CFG_SP_STEP: begin
                    r_cfg.setpoint_step <= i_cfg_data[lldr_pkg::STEP_W-1:0];
                end
                lldr_pkg::CFG_SP_MIN: begin
                    r_cfg.setpoint_min <= i_cfg_data[lldr_pkg::SP_W-1:0];
                end
                lldr_pkg::CFG_SP_MAX: begin
                    r_cfg.setpoint_max <= i_cfg_data[lldr_pkg::SP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_in_take) begin
            r_in_vld <= 1'b1;
        end else if (w_fire) begin
            r_in_vld <= 1'b0;
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_adc             <= i_in.adc_sample;
            r_btn.plus_level  <= i_in.plus_level;
            r_btn.minus_level <= i_in.minus_level;
            r_btn.menu_edge   <= i_in.menu_edge;
        end
    end

    // sensor code to lux
    assign w_lux = lldr_pkg::LUX_ROM[r_adc];

    lldr_setpoint u_setpoint (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (w_fire),
        .i_btn        (r_btn),
        .i_cfg        (r_cfg),
        .o_status     (w_status),
        .o_target_cur (w_target_cur)
    );

    lldr_duty u_duty (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_status    (w_status),
        .i_lux       (w_lux),
        .i_deadband  (r_cfg.deadband),
        .o_duty_next (w_duty_next),
        .o_led_next  (w_led_next)
    );

    // result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_fire) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_duty <= w_duty_next;
            r_led  <= w_led_next;
            r_lux  <= w_lux;
            r_sp   <= w_status.target;
            r_menu <= w_status.menu_next;
        end
    end

    assign o_out.valid          = r_out_vld;
    assign o_out.duty_percent   = r_duty;
    assign o_out.led_bar        = r_led;
    assign o_out.lux_value      = r_lux;
    assign o_out.setpoint_value = r_sp;
    assign o_out.menu_mode      = r_menu;

    // duty never leaves its range
    `ASSERT_NOW(a_duty_range, r_out_vld, r_duty <= lldr_pkg::DUTY_W'(lldr_pkg::DUTY_FULL))
    // led bar is a thermometer code
    `ASSERT_NOW(a_led_thermo, r_out_vld, (r_led & (r_led + lldr_pkg::LED_W'(1))) == '0)
    // a full input register behind a stalled result blocks new beats
    `ASSERT_NOW(a_in_block, r_in_vld && r_out_vld && !o_out.ready, !i_in.ready)
    // setpoint only moves in menu mode
    `ASSERT_NEXT(a_sp_menu_only, w_fire && !w_status.menu_next, $stable(w_target_cur))
endmodule
